/* rtl/dfs_pkg.sv */
// shared types and constants of the delimited field splitter
package dfs_pkg;

    localparam int MAX_SEPARATORS  = 4;
    localparam int NUM_SEP_REGS    = 4;
    localparam int SEP_LIMIT       = (MAX_SEPARATORS < NUM_SEP_REGS) ? MAX_SEPARATORS
                                                                     : NUM_SEP_REGS;
    localparam int DEF_MAX_HELD    = 16;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;

    localparam logic [7:0] SLASH_BYTE  = 8'h2F;
    localparam logic [7:0] BLANK_LIMIT = 8'h20;

    typedef enum logic [2:0] {
        REG_SEP_COUNT      = 3'd0,
        REG_SEP_A          = 3'd1,
        REG_SEP_B          = 3'd2,
        REG_SEP_C          = 3'd3,
        REG_SEP_D          = 3'd4,
        REG_COMMENT_FILTER = 3'd5,
        REG_TRIM_ENABLE    = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_COMMENT = 2'd2
    } item_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_REPLAY,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        item_kind_t item_kind;
        logic [7:0] out_byte;
        logic       line_done;
        logic       run_last;
        logic       trim_overflow;
    } out_item_t;

    typedef struct packed {
        logic [2:0]                   sep_count;
        logic [NUM_SEP_REGS-1:0][7:0] separators;
        logic                         comment_filter;
        logic                         trim_enable;
    } cfg_t;

endpackage

/* rtl/dfs_ram.sv */
// generic single-write, single-read memory with registered read data
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dfs_cfg.sv */
// apb register bank holding separators, separator count and filter/trim controls
module dfs_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dfs_pkg::APB_DATA_W-1:0] prdata,
    output dfs_pkg::cfg_t                  cfg
);

    dfs_pkg::cfg_t      cfg_reg;
    dfs_pkg::cfg_t      cfg_next;
    dfs_pkg::reg_index_t reg_sel;
    logic               wr_strobe;

    assign reg_sel   = dfs_pkg::reg_index_t'(paddr[dfs_pkg::APB_ADDR_W-1:2]);
    assign wr_strobe = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_strobe) begin
            unique case (reg_sel)
                dfs_pkg::REG_SEP_COUNT:      cfg_next.sep_count      = pwdata[2:0];
                dfs_pkg::REG_SEP_A:          cfg_next.separators[0]  = pwdata[7:0];
                dfs_pkg::REG_SEP_B:          cfg_next.separators[1]  = pwdata[7:0];
                dfs_pkg::REG_SEP_C:          cfg_next.separators[2]  = pwdata[7:0];
                dfs_pkg::REG_SEP_D:          cfg_next.separators[3]  = pwdata[7:0];
                dfs_pkg::REG_COMMENT_FILTER: cfg_next.comment_filter = pwdata[0];
                dfs_pkg::REG_TRIM_ENABLE:    cfg_next.trim_enable    = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            dfs_pkg::REG_SEP_COUNT:      prdata[2:0] = cfg_reg.sep_count;
            dfs_pkg::REG_SEP_A:          prdata[7:0] = cfg_reg.separators[0];
            dfs_pkg::REG_SEP_B:          prdata[7:0] = cfg_reg.separators[1];
            dfs_pkg::REG_SEP_C:          prdata[7:0] = cfg_reg.separators[2];
            dfs_pkg::REG_SEP_D:          prdata[7:0] = cfg_reg.separators[3];
            dfs_pkg::REG_COMMENT_FILTER: prdata[0]   = cfg_reg.comment_filter;
            dfs_pkg::REG_TRIM_ENABLE:    prdata[0]   = cfg_reg.trim_enable;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{sep_count: 3'd0, separators: '0, comment_filter: 1'b0,
                         trim_enable: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/dfs_sep_match.sv */
// compares one byte against the active separator bytes
module dfs_sep_match (
    input  dfs_pkg::cfg_t cfg,
    input  logic [7:0]    byte_in,
    output logic          hit
);

    logic [2:0] active_n;

    // count above the number of separator slots acts as all slots
    assign active_n = (cfg.sep_count > 3'(dfs_pkg::SEP_LIMIT)) ? 3'(dfs_pkg::SEP_LIMIT)
                                                             : cfg.sep_count;

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < dfs_pkg::NUM_SEP_REGS; i++) begin
            if ((3'(i) < active_n) && (cfg.separators[i] == byte_in)) begin
                hit = 1'b1;
            end
        end
    end

endmodule

/* rtl/delimited_field_splitter.sv */
// top level: line tokenizer splitting a byte stream into fields at separator bytes
// an item is taken in IDLE and worked in PROC; comment-line bytes and a held leading
// slash are only taken in IDLE; text after held blanks first replays them in REPLAY,
// resolving a held slash adds a second PROC pass, and a line's last byte adds FINAL
// results are loaded into a registered output stage; output stalls hold the block
// synchronous active-low reset clears control state; held-byte memory is not cleared
module delimited_field_splitter #(
    parameter int MAX_HELD_BLANKS = dfs_pkg::DEF_MAX_HELD
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dfs_pkg::in_item_t              s_item,
    // result item channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output dfs_pkg::out_item_t             m_item,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    // held-count holds 0..MAX, memory address spans 0..MAX-1
    localparam int CW = $clog2(MAX_HELD_BLANKS + 1);
    localparam int AW = (MAX_HELD_BLANKS > 1) ? $clog2(MAX_HELD_BLANKS) : 1;

    dfs_pkg::cfg_t      cfg;
    dfs_pkg::state_t    state_reg, state_next;

    // per-line control state
    logic [1:0]         line_pos_reg, line_pos_next;
    logic               slash_held_reg, slash_held_next;
    logic               comment_reg, comment_next;
    logic               content_reg, content_next;
    logic [CW-1:0]      held_count_reg, held_count_next;
    logic               ovf_reg, ovf_next;

    // the item being worked on
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic               cur_slash_reg, cur_slash_next;
    logic [AW-1:0]      idx_reg, idx_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    dfs_pkg::out_item_t m_item_reg, m_item_next;

    // held-byte memory port
    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [7:0]         ram_rd_data;

    // classification
    logic [7:0]         cur_byte;
    logic               x_sep, x_blank, x_text;
    logic               b_sep, b_blank;
    logic               in_acc, in_last, in_slash, hold_cond;
    logic               out_free;
    logic               emit;
    dfs_pkg::out_item_t emit_item;
    logic               proc_needs_out, proc_to_replay, proc_done;
    logic               final_needs_out, final_done;
    logic [CW-1:0]      idx_inc;
    logic               replay_more;
    logic               proc_run_last;

    dfs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // a held leading slash is worked through before the byte that followed it
    assign cur_byte = cur_slash_reg ? dfs_pkg::SLASH_BYTE : byte_reg;

    dfs_sep_match u_match_cur (
        .cfg     (cfg),
        .byte_in (cur_byte),
        .hit     (x_sep)
    );

    dfs_sep_match u_match_byte (
        .cfg     (cfg),
        .byte_in (byte_reg),
        .hit     (b_sep)
    );

    dfs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_HELD_BLANKS)
    ) u_held_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (held_count_reg[AW-1:0]),
        .wr_data (cur_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // byte classes: separator, trimmable blank, or field text
    assign x_blank = !x_sep && cfg.trim_enable && (cur_byte <= dfs_pkg::BLANK_LIMIT);
    assign x_text  = !x_sep && !x_blank;
    assign b_blank = !b_sep && cfg.trim_enable && (byte_reg <= dfs_pkg::BLANK_LIMIT);

    assign s_ready   = (state_reg == dfs_pkg::ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign in_last   = s_item.line_end;
    assign in_slash  = (s_item.char_byte == dfs_pkg::SLASH_BYTE);
    // first byte a slash, filter on, line goes on: hold it until the second byte
    assign hold_cond = (line_pos_reg == 2'd0) && cfg.comment_filter && in_slash && !in_last;

    // output register can take a result this cycle
    assign out_free = !m_valid_reg || m_ready;

    // text after held blanks first replays them from memory
    assign proc_to_replay = x_text && (held_count_reg != '0);
    assign proc_needs_out = x_sep || (x_text && (held_count_reg == '0));
    assign proc_done      = !proc_to_replay && (!proc_needs_out || out_free);

    // closing result: comment marker, or field end unless a separator closed it already
    assign final_needs_out = comment_reg || !b_sep;
    assign final_done      = !final_needs_out || out_free;

    assign idx_inc     = CW'(idx_reg) + CW'(1);
    assign replay_more = (idx_inc < held_count_reg);

    // in the slash pass, the slash result is last only when the next byte is dropped
    // as a blank and the line goes on; in the byte pass a field byte is followed by
    // the closing field end on a line's last byte
    assign proc_run_last = cur_slash_reg ? (!last_reg && b_blank)
                                         : (x_sep || !last_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dfs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (comment_reg) begin
                        state_next = in_last ? dfs_pkg::ST_FINAL : dfs_pkg::ST_IDLE;
                    end else if (slash_held_reg) begin
                        if (in_slash) begin
                            state_next = in_last ? dfs_pkg::ST_FINAL : dfs_pkg::ST_IDLE;
                        end else begin
                            state_next = dfs_pkg::ST_PROC;
                        end
                    end else if (hold_cond) begin
                        state_next = dfs_pkg::ST_IDLE;
                    end else begin
                        state_next = dfs_pkg::ST_PROC;
                    end
                end
            end
            dfs_pkg::ST_PROC: begin
                if (proc_to_replay) begin
                    state_next = dfs_pkg::ST_REPLAY;
                end else if (proc_done) begin
                    if (cur_slash_reg) begin
                        state_next = dfs_pkg::ST_PROC;
                    end else begin
                        state_next = last_reg ? dfs_pkg::ST_FINAL : dfs_pkg::ST_IDLE;
                    end
                end
            end
            dfs_pkg::ST_REPLAY: begin
                if (out_free && !replay_more) begin
                    state_next = dfs_pkg::ST_PROC;
                end
            end
            dfs_pkg::ST_FINAL: begin
                if (final_done) begin
                    state_next = dfs_pkg::ST_IDLE;
                end
            end
            default: state_next = dfs_pkg::ST_IDLE;
        endcase
    end

    // datapath and result generation
    always_comb begin
        line_pos_next   = line_pos_reg;
        slash_held_next = slash_held_reg;
        comment_next    = comment_reg;
        content_next    = content_reg;
        held_count_next = held_count_reg;
        ovf_next        = ovf_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        cur_slash_next  = cur_slash_reg;
        idx_next        = idx_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        emit            = 1'b0;
        emit_item       = '0;

        unique case (state_reg)
            dfs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    byte_next      = s_item.char_byte;
                    last_next      = in_last;
                    cur_slash_next = 1'b0;
                    if (in_last) begin
                        line_pos_next = 2'd0;
                    end else if (line_pos_reg != 2'd2) begin
                        line_pos_next = line_pos_reg + 2'd1;
                    end
                    if (comment_reg) begin
                        // bytes of a dropped line give nothing
                    end else if (slash_held_reg) begin
                        slash_held_next = 1'b0;
                        if (in_slash) begin
                            comment_next = 1'b1;
                        end else begin
                            cur_slash_next = 1'b1;
                        end
                    end else if (hold_cond) begin
                        slash_held_next = 1'b1;
                    end
                end
            end
            dfs_pkg::ST_PROC: begin
                if (x_sep) begin
                    if (out_free) begin
                        emit                    = 1'b1;
                        emit_item.item_kind     = dfs_pkg::KIND_END;
                        emit_item.trim_overflow = ovf_reg;
                        emit_item.run_last      = proc_run_last;
                        emit_item.line_done     = proc_run_last && last_reg;
                        content_next            = 1'b0;
                        held_count_next         = '0;
                        ovf_next                = 1'b0;
                    end
                end else if (x_blank) begin
                    // leading blanks vanish, inner ones wait in memory
                    if (content_reg) begin
                        if (held_count_reg < CW'(MAX_HELD_BLANKS)) begin
                            ram_wr_en       = 1'b1;
                            held_count_next = held_count_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end else if (proc_to_replay) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    idx_next    = '0;
                end else if (out_free) begin
                    emit                = 1'b1;
                    emit_item.item_kind = dfs_pkg::KIND_BYTE;
                    emit_item.out_byte  = cur_byte;
                    emit_item.run_last  = proc_run_last;
                    emit_item.line_done = proc_run_last && last_reg;
                    content_next        = 1'b1;
                end
                if (proc_done && cur_slash_reg) begin
                    cur_slash_next = 1'b0;
                end
            end
            dfs_pkg::ST_REPLAY: begin
                // one held byte per cycle while the output is free, next read issued as this one leaves
                if (out_free) begin
                    emit                = 1'b1;
                    emit_item.item_kind = dfs_pkg::KIND_BYTE;
                    emit_item.out_byte  = ram_rd_data;
                    if (replay_more) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_inc[AW-1:0];
                        idx_next    = idx_inc[AW-1:0];
                    end else begin
                        held_count_next = '0;
                    end
                end
            end
            dfs_pkg::ST_FINAL: begin
                if (final_done) begin
                    if (final_needs_out) begin
                        emit                = 1'b1;
                        emit_item.run_last  = 1'b1;
                        emit_item.line_done = 1'b1;
                        if (comment_reg) begin
                            emit_item.item_kind = dfs_pkg::KIND_COMMENT;
                        end else begin
                            emit_item.item_kind     = dfs_pkg::KIND_END;
                            emit_item.trim_overflow = ovf_reg;
                        end
                    end
                    // line boundary: all per-line state starts over
                    slash_held_next = 1'b0;
                    comment_next    = 1'b0;
                    content_next    = 1'b0;
                    held_count_next = '0;
                    ovf_next        = 1'b0;
                    cur_slash_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // output register: loads a result whenever it is free
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_item_next  = emit_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dfs_pkg::ST_IDLE;
            line_pos_reg   <= 2'd0;
            slash_held_reg <= 1'b0;
            comment_reg    <= 1'b0;
            content_reg    <= 1'b0;
            held_count_reg <= '0;
            ovf_reg        <= 1'b0;
            cur_slash_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            line_pos_reg   <= line_pos_next;
            slash_held_reg <= slash_held_next;
            comment_reg    <= comment_next;
            content_reg    <= content_next;
            held_count_reg <= held_count_next;
            ovf_reg        <= ovf_next;
            cur_slash_reg  <= cur_slash_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // replay never reads past the held bytes
    a_replay_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dfs_pkg::ST_REPLAY) |-> (CW'(idx_reg) < held_count_reg))
        else $error("replay index beyond held count");

    // a held slash and a dropped line never coexist
    a_slash_comment: assert property (@(posedge aclk) disable iff (!aresetn)
        !(slash_held_reg && comment_reg))
        else $error("slash held on a comment line");

    // closing a line clears the per-line state
    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dfs_pkg::ST_FINAL && final_done) |=>
            (!content_reg && held_count_reg == '0 && !ovf_reg && !comment_reg
             && line_pos_reg == 2'd0))
        else $error("line state not cleared at line end");

    // a line-done result only comes from an item that ends its line
    a_line_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_item.line_done) |-> (last_reg && emit_item.run_last))
        else $error("line done on an item that does not end the line");

endmodule

/* tb/sv/delimited_field_splitter_test.sv */
// testbench for the delimited field splitter: field predictor, result checks, stimulus

// predicts the field items of each accepted byte and checks results in order
class field_split_checker;
    logic [2:0]          sep_count;
    logic [7:0]          sep_byte [dfs_pkg::NUM_SEP_REGS];
    bit                  filter_on;
    bit                  trim_on;

    logic [1:0]          line_pos;
    bit                  slash_pending;
    bit                  in_comment;
    bit                  has_content;
    bit                  overflow_hit;
    logic [7:0]          blanks [dfs_pkg::DEF_MAX_HELD];
    int unsigned         blank_count;

    dfs_pkg::out_item_t  pending_fields [$];
    dfs_pkg::out_item_t  step_out [$];
    int                  errors;

    function new();
        sep_count     = '0;
        foreach (sep_byte[i]) sep_byte[i] = '0;
        filter_on     = 1'b0;
        trim_on       = 1'b1;
        line_pos      = '0;
        slash_pending = 1'b0;
        in_comment    = 1'b0;
        has_content   = 1'b0;
        overflow_hit  = 1'b0;
        blank_count   = 0;
        errors        = 0;
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 30) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function void set_register(dfs_pkg::reg_index_t idx, logic [31:0] value);
        case (idx)
            dfs_pkg::REG_SEP_COUNT:      sep_count   = value[2:0];
            dfs_pkg::REG_SEP_A:          sep_byte[0] = value[7:0];
            dfs_pkg::REG_SEP_B:          sep_byte[1] = value[7:0];
            dfs_pkg::REG_SEP_C:          sep_byte[2] = value[7:0];
            dfs_pkg::REG_SEP_D:          sep_byte[3] = value[7:0];
            dfs_pkg::REG_COMMENT_FILTER: filter_on   = value[0];
            dfs_pkg::REG_TRIM_ENABLE:    trim_on     = value[0];
            default: ;
        endcase
    endfunction

    // counts above the number of separator registers act as all of them
    function int active_separators();
        int n;
        n = int'(sep_count);
        if (n > dfs_pkg::SEP_LIMIT) n = dfs_pkg::SEP_LIMIT;
        return n;
    endfunction

    function bit is_sep(logic [7:0] b);
        int n;
        n = active_separators();
        for (int i = 0; i < n; i++) begin
            if (sep_byte[i] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    function void emit(dfs_pkg::item_kind_t kind, logic [7:0] b, bit ovf);
        dfs_pkg::out_item_t r;
        r.item_kind     = kind;
        r.out_byte      = b;
        r.line_done     = 1'b0;
        r.run_last      = 1'b0;
        r.trim_overflow = ovf;
        step_out.push_back(r);
    endfunction

    function void close_field();
        emit(dfs_pkg::KIND_END, 8'h00, overflow_hit);
        has_content  = 1'b0;
        blank_count  = 0;
        overflow_hit = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
        if (is_sep(b)) begin
            close_field();
            return;
        end
        if (trim_on && b <= dfs_pkg::BLANK_LIMIT) begin
            if (!has_content) return;
            if (blank_count < dfs_pkg::DEF_MAX_HELD) begin
                blanks[blank_count] = b;
                blank_count++;
            end else begin
                overflow_hit = 1'b1;
            end
            return;
        end
        for (int i = 0; i < blank_count; i++) emit(dfs_pkg::KIND_BYTE, blanks[i], 1'b0);
        blank_count = 0;
        emit(dfs_pkg::KIND_BYTE, b, 1'b0);
        has_content = 1'b1;
    endfunction

    function void note_item(dfs_pkg::in_item_t it);
        logic [7:0]         b;
        bit                 last;
        dfs_pkg::out_item_t tail;
        b    = it.char_byte;
        last = it.line_end;
        step_out.delete();

        if (!in_comment) begin
            if (slash_pending) begin
                slash_pending = 1'b0;
                if (b == dfs_pkg::SLASH_BYTE) begin
                    in_comment = 1'b1;
                end else begin
                    take_byte(dfs_pkg::SLASH_BYTE);
                    take_byte(b);
                end
            end else if (line_pos == 0 && filter_on && b == dfs_pkg::SLASH_BYTE && !last) begin
                slash_pending = 1'b1;
            end else begin
                take_byte(b);
            end
        end

        if (last) begin
            if (in_comment) begin
                emit(dfs_pkg::KIND_COMMENT, 8'h00, 1'b0);
            end else if (!is_sep(b)) begin
                close_field();
            end
            line_pos      = '0;
            slash_pending = 1'b0;
            in_comment    = 1'b0;
            has_content   = 1'b0;
            blank_count   = 0;
            overflow_hit  = 1'b0;
        end else if (line_pos < 2) begin
            line_pos++;
        end

        if (step_out.size() > 0) begin
            tail          = step_out[step_out.size()-1];
            tail.run_last = 1'b1;
            if (last) tail.line_done = 1'b1;
            step_out[step_out.size()-1] = tail;
        end
        foreach (step_out[i]) pending_fields.push_back(step_out[i]);
    endfunction

    function void check_result(dfs_pkg::out_item_t got);
        dfs_pkg::out_item_t want;
        if (pending_fields.size() == 0) begin
            report($sformatf("unexpected result kind %0d byte %02h",
                             got.item_kind, got.out_byte));
            return;
        end
        want = pending_fields.pop_front();
        if (got.item_kind !== want.item_kind)
            report($sformatf("item_kind %0d, want %0d", got.item_kind, want.item_kind));
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.line_done !== want.line_done)
            report($sformatf("line_done %b, want %b", got.line_done, want.line_done));
        if (got.run_last !== want.run_last)
            report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        if (got.trim_overflow !== want.trim_overflow)
            report($sformatf("trim_overflow %b, want %b",
                             got.trim_overflow, want.trim_overflow));
    endfunction
endclass

module delimited_field_splitter_test;

    // bench-side clock, reset and every block input start at known values
    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    dfs_pkg::in_item_t              s_item  = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    dfs_pkg::out_item_t             m_item;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [dfs_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [dfs_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [dfs_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    field_split_checker    split_check;

    // handshake seen at the last rising edge, read by the sender at the falling edge
    bit                    in_accepted = 1'b0;

    // sender burst shaping
    int                    burst_left  = 0;

    // long receiver hold-off, requested by the stimulus, counted by the receiver
    int                    hold_asked  = 0;
    int                    hold_seen   = 0;
    int                    hold_left   = 0;
    int                    rx_mode     = 0;
    int                    rx_cycle    = 0;

    // bytes of the line being built
    logic [7:0]            line_buf [$];

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;

    delimited_field_splitter #(
        .MAX_HELD_BLANKS (dfs_pkg::DEF_MAX_HELD)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 unit period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // everything is sampled at the rising edge, before the block updates
    always @(posedge aclk) begin
        in_accepted = s_valid && s_ready;
        if (aresetn) begin
            // results leave first: a result can never stem from an item taken at this edge
            if (m_valid && m_ready) split_check.check_result(m_item);
            if (s_valid && s_ready) split_check.note_item(s_item);
        end
    end

    // receiver: switches among random stall patterns, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 0);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((rx_cycle % 5) < 3);
            endcase
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    end

    // hard stop if the block hangs
    initial begin
        #20000000;
        $display("delimited_field_splitter_test NOT OK");
        $finish;
    end

    // offer one item, idling between bursts; returns at the falling edge after acceptance
    task automatic offer_item(dfs_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(negedge aclk); while (!in_accepted);
    endtask

    // send the bytes of line_buf, marking the last one as line end when asked
    task automatic send_line(bit close_line);
        dfs_pkg::in_item_t it;
        foreach (line_buf[i]) begin
            it.char_byte = line_buf[i];
            it.line_end  = close_line && (i == line_buf.size() - 1);
            offer_item(it);
        end
    endtask

    // wait for every predicted item, then for the block to finish silent work
    task automatic settle();
        s_valid <= 1'b0;
        while (split_check.pending_fields.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // apb write followed by a read-back of the same register
    task automatic write_register(dfs_pkg::reg_index_t idx, logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] mask;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        // write took place at the edge just passed; now the read setup phase
        split_check.set_register(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            dfs_pkg::REG_SEP_COUNT:                     mask = 32'h7;
            dfs_pkg::REG_COMMENT_FILTER,
            dfs_pkg::REG_TRIM_ENABLE:                   mask = 32'h1;
            default:                                    mask = 32'hFF;
        endcase
        if ((rd & mask) !== (value & mask))
            split_check.report($sformatf("register %s reads %0h, want %0h",
                                         idx.name(), rd, value & mask));
        // idle gap between transfers
        @(negedge aclk);
    endtask

    task automatic configure(logic [2:0] count, logic [7:0] sa, logic [7:0] sb,
                             logic [7:0] sc, logic [7:0] sd, bit filter, bit trim);
        write_register(dfs_pkg::REG_SEP_COUNT, {29'd0, count});
        write_register(dfs_pkg::REG_SEP_A, {24'd0, sa});
        write_register(dfs_pkg::REG_SEP_B, {24'd0, sb});
        write_register(dfs_pkg::REG_SEP_C, {24'd0, sc});
        write_register(dfs_pkg::REG_SEP_D, {24'd0, sd});
        write_register(dfs_pkg::REG_COMMENT_FILTER, {31'd0, filter});
        write_register(dfs_pkg::REG_TRIM_ENABLE, {31'd0, trim});
    endtask

    // text byte mix: separators, blanks, slashes, anything, printable
    function automatic logic [7:0] pick_byte();
        int r;
        int n;
        r = $urandom_range(0, 9);
        n = split_check.active_separators();
        if (r <= 1 && n > 0) return split_check.sep_byte[$urandom_range(0, n - 1)];
        if (r <= 3) return 8'($urandom_range(0, dfs_pkg::BLANK_LIMIT));
        if (r == 4) return dfs_pkg::SLASH_BYTE;
        if (r == 5) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    // build one random line; the shapes aim at the comment, slash and held-blank paths
    task automatic make_line();
        int len;
        line_buf.delete();
        case ($urandom_range(0, 9))
            0, 1: begin
                // comment candidate
                line_buf.push_back(dfs_pkg::SLASH_BYTE);
                line_buf.push_back(dfs_pkg::SLASH_BYTE);
                len = $urandom_range(0, 5);
                repeat (len) line_buf.push_back(pick_byte());
            end
            2: line_buf.push_back(dfs_pkg::SLASH_BYTE);
            3: begin
                // held slash resolved by the second byte
                line_buf.push_back(dfs_pkg::SLASH_BYTE);
                line_buf.push_back(pick_byte());
                len = $urandom_range(0, 4);
                repeat (len) line_buf.push_back(pick_byte());
            end
            4: begin
                // a run of blanks near or beyond the depth of the held store
                line_buf.push_back(8'($urandom_range(33, 126)));
                len = $urandom_range(dfs_pkg::DEF_MAX_HELD - 2, dfs_pkg::DEF_MAX_HELD + 6);
                repeat (len) line_buf.push_back(8'($urandom_range(0, dfs_pkg::BLANK_LIMIT)));
                if ($urandom_range(0, 1)) line_buf.push_back(8'($urandom_range(33, 255)));
                if ($urandom_range(0, 1)) line_buf.push_back(pick_byte());
            end
            5: begin
                // blanks mixed with randomly picked bytes
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 1))
                        line_buf.push_back(8'($urandom_range(0, dfs_pkg::BLANK_LIMIT)));
                    else line_buf.push_back(pick_byte());
                end
            end
            default: begin
                len = $urandom_range(1, 14);
                repeat (len) line_buf.push_back(pick_byte());
            end
        endcase
    endtask

    initial begin
        int sent;
        split_check = new();

        // synchronous reset, held low at the start
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: no separators, trim on; leading and trailing blanks, byte extremes
        line_buf = '{8'h00, " ", "a", " ", 8'h09, "b", 8'hFF, " "};
        send_line(1'b1);
        settle();

        configure(3'd2, ",", ";", 8'hFF, 8'h00, 1'b1, 1'b1);
        // adjacent separators and a separator closing the line
        line_buf = '{"a", ",", ",", "b", ";"};
        send_line(1'b1);
        // comment line
        line_buf = '{"/", "/", "z"};
        send_line(1'b1);
        // lone slash line
        line_buf = '{"/"};
        send_line(1'b1);
        // slash held, then released by an ordinary byte
        line_buf = '{"/", "q"};
        send_line(1'b1);

        // filter switched off while a leading slash is held
        line_buf = '{"/"};
        send_line(1'b0);
        settle();
        write_register(dfs_pkg::REG_COMMENT_FILTER, 32'd0);
        line_buf = '{"/"};
        send_line(1'b1);

        // trim switched off while blanks are held inside a field
        line_buf = '{"x", " ", 8'h00};
        send_line(1'b0);
        settle();
        write_register(dfs_pkg::REG_TRIM_ENABLE, 32'd0);
        line_buf = '{"y"};
        send_line(1'b1);
        settle();

        // random part: a fresh setting per phase, extremes first
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(3'd4, 8'h00, 8'hFF, dfs_pkg::BLANK_LIMIT, ",", 1'b1, 1'b1);
                1: configure(3'd7, ",", dfs_pkg::SLASH_BYTE, 8'h09, ":", 1'b0, 1'b0);
                2: configure(3'd0, ",", ";", ":", 8'h09, 1'b1, 1'b1);
                3: configure(3'd1, ",", 8'hFF, 8'h00, ";", 1'b1, 1'b0);
                default: configure(3'($urandom_range(0, 7)),
                                   8'(($urandom_range(0, 1)) ? $urandom_range(0, 255)
                                                             : $urandom_range(33, 126)),
                                   8'($urandom_range(33, 126)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 64)), $urandom_range(0, 3) != 0,
                                   $urandom_range(0, 3) != 0);
            endcase
            // one long receiver hold-off while the sender keeps offering
            if (phase == 2) hold_asked++;
            sent = 0;
            while (sent < 38) begin
                make_line();
                sent += line_buf.size();
                send_line(1'b1);
            end
            settle();
        end

        if (split_check.errors == 0) begin
            $display("delimited_field_splitter_test OK");
        end else begin
            $display("delimited_field_splitter_test NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/dfs_pkg.sv
rtl/dfs_ram.sv
rtl/dfs_cfg.sv
rtl/dfs_sep_match.sv
rtl/delimited_field_splitter.sv
tb/sv/delimited_field_splitter_test.sv
